[rtl/ism_pkg.sv]
// Package for the IPv4 subnet membership unit: parser state type, codes and
// the per-character step functions. No dependencies.
package ism_pkg;

  localparam int unsigned AccW    = 9;
  localparam int unsigned CountW  = 3;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned PrefixW = 6;

  localparam logic [AccW-1:0]    AccMax    = 9'd511;
  localparam logic [AccW-1:0]    OctetMax  = 9'd255;
  localparam logic [AccW-1:0]    PrefixMax = 9'd32;
  localparam logic [CountW-1:0]  CountMax  = 3'd7;
  localparam logic [CountW-1:0]  OctetsIp  = 3'd4;
  localparam logic [PrefixW-1:0] PrefixFull = 6'd32;
  localparam logic [AddrW-1:0]   AllOnes   = 32'hFFFF_FFFF;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChNul   = 8'h00;

  typedef enum logic {
    PHASE_SUBNET  = 1'b0,
    PHASE_ADDRESS = 1'b1
  } phase_e;

  typedef enum logic [1:0] {
    PART_OCTET  = 2'd0,
    PART_PREFIX = 2'd1,
    PART_DONE   = 2'd2
  } part_e;

  typedef enum logic [1:0] {
    VERDICT_INSIDE    = 2'd0,
    VERDICT_OUTSIDE   = 2'd1,
    VERDICT_MALFORMED = 2'd2
  } verdict_e;

  typedef struct packed {
    phase_e               phase;
    part_e                part;
    logic [AccW-1:0]      acc;
    logic [CountW-1:0]    count;
    logic [AddrW-1:0]     value;
    logic [AddrW-1:0]     base;
    logic [PrefixW-1:0]   prefix;
    logic                 malformed;
  } ism_state_t;

  localparam ism_state_t StateReset = '{
    phase:     PHASE_SUBNET,
    part:      PART_OCTET,
    acc:       '0,
    count:     '0,
    value:     '0,
    base:      '0,
    prefix:    PrefixFull,
    malformed: 1'b0
  };

  // Decimal accumulate with saturation.
  function automatic logic [AccW-1:0] acc_digit(logic [AccW-1:0] acc, logic [7:0] c);
    logic [12:0] v;
    v = ({4'd0, acc} * 13'd10) + {5'd0, (c - ChZero)};
    return (v > {4'd0, AccMax}) ? AccMax : v[AccW-1:0];
  endfunction

  function automatic logic [AddrW-1:0] prefix_mask(logic [PrefixW-1:0] p);
    logic [AddrW-1:0] m;
    if (p >= PrefixFull) begin
      m = AllOnes;
    end else begin
      m = ~(AllOnes >> p);
    end
    return m;
  endfunction

  // Take one character into the parser state.
  function automatic ism_state_t feed(ism_state_t s, logic [7:0] c);
    ism_state_t       n;
    logic             dig;
    logic [CountW-1:0] cnt;
    logic [AddrW-1:0] val;
    n   = s;
    dig = (c >= ChZero) && (c <= ChNine);
    cnt = (s.count < CountMax) ? (s.count + 3'd1) : s.count;
    val = {s.value[AddrW-9:0], s.acc[7:0]};
    unique case (s.part)
      PART_OCTET: begin
        if (dig) begin
          n.acc = acc_digit(s.acc, c);
        end else begin
          if (s.acc > OctetMax) n.malformed = 1'b1;
          n.value = val;
          n.count = cnt;
          n.acc   = '0;
          if (c == ChDot) begin
            if (cnt >= OctetsIp) begin
              n.malformed = 1'b1;
              n.part      = PART_DONE;
            end
          end else if (s.phase == PHASE_SUBNET) begin
            // Pad missing trailing octets with zeros.
            unique case (cnt)
              3'd1:    n.base = {val[7:0], 24'd0};
              3'd2:    n.base = {val[15:0], 16'd0};
              3'd3:    n.base = {val[23:0], 8'd0};
              default: n.base = val;
            endcase
            n.part = (c == ChSlash) ? PART_PREFIX : PART_DONE;
          end else begin
            if (cnt != OctetsIp) n.malformed = 1'b1;
            n.part = PART_DONE;
          end
        end
      end
      PART_PREFIX: begin
        if (dig) begin
          n.acc = acc_digit(s.acc, c);
        end else begin
          if (s.acc > PrefixMax) begin
            n.malformed = 1'b1;
          end else begin
            n.prefix = s.acc[PrefixW-1:0];
          end
          n.acc  = '0;
          n.part = PART_DONE;
        end
      end
      default: begin
      end
    endcase
    return n;
  endfunction

endpackage

[rtl/ism_step.sv]
// One character step of the subnet membership parser, including the end of
// string handling and the verdict. Depends on ism_pkg.
module ism_step import ism_pkg::*; (
  input  ism_state_t  state_i,
  input  logic        req_type_i,
  input  logic [7:0]  char_code_i,
  input  logic        last_i,
  output ism_state_t  state_o,
  output logic        emit_o,
  output verdict_e    verdict_o
);

  ism_state_t s_char;
  ism_state_t s_end;
  logic [AddrW-1:0] mask;

  always_comb begin
    s_char = feed(state_i, char_code_i);
    s_end  = feed(s_char, ChNul);
    mask   = prefix_mask(s_end.prefix);
  end

  always_comb begin
    state_o   = state_i;
    emit_o    = 1'b0;
    verdict_o = VERDICT_OUTSIDE;
    if (req_type_i == state_i.phase) begin
      if (!last_i) begin
        state_o = s_char;
      end else if (state_i.phase == PHASE_SUBNET) begin
        // Close the subnet: mask the base, start on the address.
        state_o       = s_end;
        state_o.base  = s_end.base & mask;
        state_o.phase = PHASE_ADDRESS;
        state_o.part  = PART_OCTET;
        state_o.acc   = '0;
        state_o.count = '0;
        state_o.value = '0;
      end else begin
        state_o = StateReset;
        emit_o  = 1'b1;
        if (s_end.malformed) begin
          verdict_o = VERDICT_MALFORMED;
        end else if ((s_end.value & mask) == s_end.base) begin
          verdict_o = VERDICT_INSIDE;
        end else begin
          verdict_o = VERDICT_OUTSIDE;
        end
      end
    end
  end

endmodule

[rtl/ipv4_subnet_membership_unit.sv]
// Top level of the IPv4 subnet membership unit: input register, parser
// state register, result register. Depends on ism_pkg and ism_step.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------
//   in      | sink      | in_valid_i / in_ready_o | req_type_i, char_code_i, last_i
//   out     | source    | out_valid_o/ out_ready_i| verdict_o
//
// One character item per cycle while the output is not stalled. An item
// sits in the input register, where the parser step (digit accumulate,
// octet shift, prefix mask and compare) updates the state; a verdict
// appears in the result register the cycle after. A stall on the output
// only blocks the step while a verdict is held; the input register still
// takes one more item. Reset clears the parser to expect subnet text with
// no prefix.
module ipv4_subnet_membership_unit import ism_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       req_type_i,
  input  logic [7:0] char_code_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] verdict_o
);

  // Input register.
  logic       in_v_q;
  logic       req_q;
  logic [7:0] char_q;
  logic       last_q;

  // Parser state and result register.
  ism_state_t state_q;
  ism_state_t state_d;
  logic       emit;
  verdict_e   verdict_d;
  logic       out_v_q;
  verdict_e   verdict_q;

  logic fire;
  logic in_acc;

  // Advance the held item when the result register is free or being drained.
  assign fire       = in_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !in_v_q || fire;
  assign in_acc     = in_valid_i && in_ready_o;

  ism_step u_step (
    .state_i     (state_q),
    .req_type_i  (req_q),
    .char_code_i (char_q),
    .last_i      (last_q),
    .state_o     (state_d),
    .emit_o      (emit),
    .verdict_o   (verdict_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_acc) begin
      in_v_q <= 1'b1;
    end else if (fire) begin
      in_v_q <= 1'b0;
    end
  end

  // Payload: hold until the next accept.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q  <= req_type_i;
      char_q <= char_code_i;
      last_q <= last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (fire && emit) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      verdict_q <= verdict_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign verdict_o   = verdict_q;

  // A verdict closes the pair: the parser starts again from reset state.
  a_pair_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && emit) |=> (state_q == StateReset))
    else $error("parser state not cleared after verdict");

  // Input side only stalls while a verdict is held against a busy sink.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_v_q && out_v_q && !out_ready_i))
    else $error("input stalled without a held verdict");

  // Prefix length never leaves the legal range.
  a_prefix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.prefix <= PrefixFull)
    else $error("prefix length above 32");

endmodule

[tb/tb.sv]
// Self-checking testbench for ipv4_subnet_membership_unit: feeds subnet and
// address text one character at a time, predicts every verdict and checks it.
// Depends on ism_pkg and the unit's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ism_pkg::*;

  // Cycles with no item moving on either channel before the run is abandoned.
  localparam int StallLimit = 2000;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic       req_type_i  = 1'b0;
  logic [7:0] char_code_i = 8'h00;
  logic       last_i      = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] verdict_o;

  ipv4_subnet_membership_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .char_code_i(char_code_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .verdict_o  (verdict_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Idling controls, percent per cycle, plus the share of stray items of the
  // wrong string type slipped in between real characters.
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int stray_pct      = 0;

  // Bookkeeping for the summary and the verdict.
  int fail_count    = 0;
  int taken_items   = 0;
  int ignored_items = 0;
  int n_inside      = 0;
  int n_outside     = 0;
  int n_malformed   = 0;
  int idle_cycles   = 0;

  // Verdicts owed by the unit, oldest first.
  verdict_e verdicts_pending[$];

  // Text of the string currently being built, one byte per entry.
  logic [7:0] line_q[$];

  // ---------------------------------------------------------------------------
  // Parser prediction: our own copy of the character-by-character parser.
  // ---------------------------------------------------------------------------
  phase_e      pr_phase;
  part_e       pr_part;
  logic [8:0]  pr_acc;     // decimal accumulator, sticks at its maximum
  logic [2:0]  pr_octets;  // octets closed in the current string
  logic [31:0] pr_value;   // octets shifted in so far
  logic [31:0] pr_net;     // subnet base, padded and later masked
  logic [5:0]  pr_plen;    // prefix length, full width when none is given
  logic        pr_bad;     // sticky malformed flag for the pair

  // Return to the state after reset: subnet text expected, no prefix.
  function automatic void parser_clear();
    pr_phase  = PHASE_SUBNET;
    pr_part   = PART_OCTET;
    pr_acc    = '0;
    pr_octets = '0;
    pr_value  = '0;
    pr_net    = '0;
    pr_plen   = 6'd32;
    pr_bad    = 1'b0;
  endfunction

  // Shift one decimal digit in; clamp rather than wrap so that huge numbers
  // still read as out of range.
  function automatic logic [8:0] decimal_step(logic [8:0] acc, logic [7:0] c);
    int unsigned sum;
    sum = int'(acc) * 10 + int'(c) - int'(ChZero);
    return (sum > int'(AccMax)) ? AccMax : 9'(sum);
  endfunction

  // Network mask with the top plen bits set.
  function automatic logic [31:0] net_mask(logic [5:0] plen);
    if (plen == 6'd0) return '0;
    if (plen >= 6'd32) return '1;
    return 32'hFFFF_FFFF << (32 - int'(plen));
  endfunction

  // Advance the parser by one character; the end of a string arrives here as
  // a zero byte.
  function automatic void parse_char(logic [7:0] c);
    logic is_digit;
    int   kept;
    is_digit = (c >= ChZero) && (c <= ChNine);
    if (pr_part == PART_OCTET) begin
      if (is_digit) begin
        pr_acc = decimal_step(pr_acc, c);
      end else begin
        // Close the octet: flag overflow, shift it in, count it.
        if (pr_acc > OctetMax) pr_bad = 1'b1;
        pr_value = {pr_value[23:0], pr_acc[7:0]};
        if (pr_octets != 3'd7) pr_octets = pr_octets + 3'd1;
        pr_acc = '0;
        if (c == ChDot) begin
          // A dot after the fourth octet spoils either string.
          if (pr_octets >= 3'd4) begin
            pr_bad  = 1'b1;
            pr_part = PART_DONE;
          end
        end else if (pr_phase == PHASE_SUBNET) begin
          // Pad the missing low octets of the subnet with zeros.
          kept    = (pr_octets > 3'd4) ? 4 : int'(pr_octets);
          pr_net  = pr_value << (8 * (4 - kept));
          pr_part = (c == ChSlash) ? PART_PREFIX : PART_DONE;
        end else begin
          if (pr_octets != 3'd4) pr_bad = 1'b1;
          pr_part = PART_DONE;
        end
      end
    end else if (pr_part == PART_PREFIX) begin
      if (is_digit) begin
        pr_acc = decimal_step(pr_acc, c);
      end else begin
        if (pr_acc > PrefixMax) pr_bad = 1'b1;
        else pr_plen = pr_acc[5:0];
        pr_acc  = '0;
        pr_part = PART_DONE;
      end
    end
  endfunction

  // Take one accepted item; queue a verdict when it ends an address. Returns
  // 0 for an item of the wrong string type, which the unit ignores.
  function automatic bit predict_char(phase_e rt, logic [7:0] c, logic lst);
    logic [31:0] mask;
    if (rt != pr_phase) return 1'b0;
    parse_char(c);
    if (!lst) return 1'b1;
    parse_char(ChNul);
    if (pr_phase == PHASE_SUBNET) begin
      pr_net    = pr_net & net_mask(pr_plen);
      pr_phase  = PHASE_ADDRESS;
      pr_part   = PART_OCTET;
      pr_acc    = '0;
      pr_octets = '0;
      pr_value  = '0;
      return 1'b1;
    end
    mask = net_mask(pr_plen);
    if (pr_bad) verdicts_pending.push_back(VERDICT_MALFORMED);
    else if ((pr_value & mask) == pr_net) verdicts_pending.push_back(VERDICT_INSIDE);
    else verdicts_pending.push_back(VERDICT_OUTSIDE);
    parser_clear();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sending side.
  // ---------------------------------------------------------------------------

  // Offer one item, with a random gap first; hold it until it is taken.
  task automatic send_char(input phase_e rt, input logic [7:0] c, input logic lst);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= rt;
    char_code_i <= c;
    last_i      <= lst;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    if (predict_char(rt, c, lst)) taken_items++;
    else ignored_items++;
  endtask

  // Random character biased towards the ones the parser cares about.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return ChZero + 8'($urandom_range(0, 9));
      4:          return ChDot;
      5:          return ChSlash;
      6:          return ChNul;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Send the built string, marking its final byte, then empty the buffer.
  task automatic send_line(input phase_e rt);
    phase_e other;
    other = (rt == PHASE_SUBNET) ? PHASE_ADDRESS : PHASE_SUBNET;
    foreach (line_q[i]) begin
      if ($urandom_range(0, 99) < stray_pct)
        send_char(other, pick_char(), 1'($urandom_range(0, 1)));
      send_char(rt, line_q[i], i == line_q.size() - 1);
    end
    line_q.delete();
  endtask

  // Hold the input idle until every owed verdict is out, then let the
  // pipeline settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (verdicts_pending.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic void add_str(string s);
    foreach (s[i]) line_q.push_back(s[i]);
  endfunction

  function automatic void add_num(int v);
    add_str($sformatf("%0d", v));
  endfunction

  // One octet of text: usually the value, sometimes empty, padded or too big.
  function automatic void add_octet(logic [7:0] v);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      add_num($urandom_range(256, 999));
    end else if (r < 8 || (v == 8'd0 && r < 30)) begin
      // leave the octet empty
    end else begin
      if (r >= 88) line_q.push_back(ChZero);
      add_num(int'(v));
    end
  endfunction

  // A few loose bytes, whether as a whole string or as a trailing tail.
  function automatic void add_noise(int max_len);
    repeat ($urandom_range(1, max_len)) line_q.push_back(pick_char());
  endfunction

  // ---------------------------------------------------------------------------
  // Checking side: the sink stalls at random, each verdict meets the oldest
  // prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    verdict_e want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdicts_pending.size() == 0) begin
        $error("verdict: none expected, got %0d", verdict_o);
        fail_count++;
      end else begin
        want = verdicts_pending.pop_front();
        if (verdict_o !== want) begin
          $error("verdict: expected %0d, got %0d", want, verdict_o);
          fail_count++;
        end
        case (want)
          VERDICT_INSIDE:  n_inside++;
          VERDICT_OUTSIDE: n_outside++;
          default:         n_malformed++;
        endcase
      end
    end
  end

  // Watchdog: abandon the run once nothing has moved for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Timeout: no item moved for %0d cycles", StallLimit);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed cases.
  // ---------------------------------------------------------------------------

  // Stray address item while subnet text is expected, a bare slash (prefix
  // zero, so everything matches), then an address cut short by a zero byte
  // with junk after it.
  task automatic test_empty_prefix();
    send_char(PHASE_ADDRESS, "7", 1'b1);
    add_str("/");
    send_line(PHASE_SUBNET);
    add_str("...");
    line_q.push_back(ChNul);
    line_q.push_back(8'hFF);
    send_line(PHASE_ADDRESS);
  endtask

  // Octet far beyond 255: the accumulator clamps and the pair is malformed.
  task automatic test_octet_overflow();
    add_str("999");
    send_line(PHASE_SUBNET);
    add_str("...");
    send_line(PHASE_ADDRESS);
  endtask

  // Prefix of 33 is rejected.
  task automatic test_prefix_overflow();
    add_str("/33");
    send_line(PHASE_SUBNET);
    add_str("...");
    send_line(PHASE_ADDRESS);
  endtask

  // Subnet of a lone zero byte, then an address with a dot after its fourth
  // octet.
  task automatic test_extra_dot();
    line_q.push_back(ChNul);
    send_line(PHASE_SUBNET);
    add_str("....");
    send_line(PHASE_ADDRESS);
  endtask

  // Address with only two octets.
  task automatic test_short_address();
    line_q.push_back(ChNul);
    send_line(PHASE_SUBNET);
    add_str(".");
    send_line(PHASE_ADDRESS);
  endtask

  // No prefix means exact match: 1.0.0.0 against 2.0.0.0 lies outside.
  task automatic test_exact_match();
    add_str("1");
    send_line(PHASE_SUBNET);
    add_str("2...");
    send_line(PHASE_ADDRESS);
  endtask

  // ---------------------------------------------------------------------------
  // Random pairs: mostly well-formed subnet and address text, with addresses
  // drawn inside the subnet half the time, plus noise and stray items.
  // ---------------------------------------------------------------------------
  task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                     input int n_chars);
    int          start;
    int          octs;
    int          addr_octs;
    int          plen;
    int          r;
    bit          has_prefix;
    logic [31:0] base;
    logic [31:0] addr;
    logic [31:0] match_mask;
    src_idle_pct   = src_pct;
    sink_stall_pct = snk_pct;
    stray_pct      = 3;
    start          = taken_items;
    while (taken_items - start < n_chars) begin
      octs       = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 4;
      base       = $urandom() & net_mask(6'(8 * octs));
      has_prefix = ($urandom_range(0, 99) >= 35);
      plen       = $urandom_range(0, 32);
      match_mask = has_prefix ? net_mask(6'(plen)) : '1;

      // Subnet text.
      if ($urandom_range(0, 99) < 8) begin
        add_noise(10);
      end else begin
        for (int i = 0; i < octs; i++) begin
          if (i != 0) line_q.push_back(ChDot);
          add_octet(base[31 - 8 * i -: 8]);
        end
        if (octs == 4 && $urandom_range(0, 99) < 5) begin
          line_q.push_back(ChDot);
          add_octet(8'($urandom_range(0, 255)));
        end
        if (has_prefix) begin
          line_q.push_back(ChSlash);
          r = $urandom_range(0, 99);
          if (r < 6) begin
            // empty prefix
          end else if (r < 12) begin
            add_num($urandom_range(33, 999));
          end else begin
            if (r >= 85) line_q.push_back(ChZero);
            add_num(plen);
          end
        end
        if ($urandom_range(0, 99) < 20) add_noise(4);
      end
      send_line(PHASE_SUBNET);

      // Address text.
      addr = $urandom_range(0, 1) ? ((base & match_mask) | ($urandom() & ~match_mask))
                                  : $urandom();
      if ($urandom_range(0, 99) < 8) begin
        add_noise(10);
      end else begin
        addr_octs = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 5) : 4;
        for (int i = 0; i < addr_octs; i++) begin
          if (i != 0) line_q.push_back(ChDot);
          add_octet((i < 4) ? addr[31 - 8 * i -: 8] : 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 99) < 20) add_noise(4);
      end
      send_line(PHASE_ADDRESS);

      // Now and then starve the unit until it has caught up.
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    parser_clear();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_prefix();
    test_octet_overflow();
    test_prefix_overflow();
    test_extra_dot();
    test_short_address();
    test_exact_match();
    wait_drained();

    test_random_traffic(0, 0, 425);
    test_random_traffic(58, 0, 425);
    test_random_traffic(0, 58, 425);
    test_random_traffic(30, 30, 425);

    $display("Sent %0d parsed and %0d stray characters, no idling, idle sender, %s",
             taken_items, ignored_items, "stalling sink and both.");
    $display("Verdicts checked: %0d inside, %0d outside, %0d malformed.",
             n_inside, n_outside, n_malformed);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
